>>> rtl/pabc_pkg.sv
// shared types and constants of the per-address byte counter table
`default_nettype none

package pabc_pkg;

    // widest slot index over the supported table sizes
    localparam int SLOT_MAX_W = 8;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = 32;
    localparam int RC_W       = 5;

    typedef logic [SLOT_MAX_W-1:0] t_slot;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_ADJUST  = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_CLAMPED  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_op                      operation;
        logic [KEY_W-1:0]         sink_address;
        logic signed [CNT_W-1:0]  byte_delta;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [CNT_W-1:0]  total_received;
        logic [CNT_W-1:0]  pending_bytes;
        logic [RC_W-1:0]   record_count;
    } t_out_item;

    // key lookup result
    typedef struct packed {
        logic   hit;
        t_slot  hit_slot;
        logic   free_any;
        t_slot  free_slot;
    } t_look;

    // outcome of one update: counter write and result fields
    typedef struct packed {
        logic              we;
        logic              alloc;
        t_slot             slot;
        logic [CNT_W-1:0]  total;
        logic [CNT_W-1:0]  pending;
        t_status           status;
    } t_upd;

endpackage

`default_nettype wire

>>> rtl/per_address_byte_counter_table.sv
// Per-address byte counter table: up to ENTRIES records keyed by a 32-bit
// address, each with a received-bytes and a pending-bytes counter. In the
// cycle an item is accepted its key is compared against all stored keys
// held in registers and the counter ram read is issued; in the update
// state that follows, the saturating update is written back to the counter
// ram and the result is loaded into the output register once that register
// is free or being taken. The output register waits for the receiver, and
// while a finished result waits there the next item is still accepted; a
// further item is held off while the update state is busy. New records take
// the lowest free slot. Counters clamp to 0 to 2**32-1 with status 4 reported.
`default_nettype none

module per_address_byte_counter_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pabc_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pabc_pkg::t_out_item       o_out
);

    localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = 2 * pabc_pkg::CNT_W;

    pabc_pkg::t_state     r_state;
    pabc_pkg::t_state     n_state;
    pabc_pkg::t_in_item   r_item;
    pabc_pkg::t_look      r_look;
    pabc_pkg::t_look      cam_look;
    pabc_pkg::t_upd       upd;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        cnt_after;
    logic [CW+4:0]        cnt_ext;
    logic                 r_out_valid;
    pabc_pkg::t_out_item  r_out;
    logic [DW-1:0]        ram_rdata;
    logic [SW-1:0]        ram_raddr;
    logic                 accept;
    logic                 done;

    // handshake
    assign accept      = i_in_valid && (r_state == pabc_pkg::S_IDLE);
    assign done        = (r_state == pabc_pkg::S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != pabc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // key store and lookup
    pabc_cam #(
        .ENTRIES (ENTRIES),
        .SW      (SW)
    ) u_cam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (i_in.sink_address),
        .i_alloc   (done && upd.alloc),
        .i_slot    (upd.slot[SW-1:0]),
        .i_new_key (r_item.sink_address),
        .o_look    (cam_look)
    );

    // counter ram read address: live lookup while idle, held during update
    assign ram_raddr = (r_state == pabc_pkg::S_IDLE) ? cam_look.hit_slot[SW-1:0]
                                                     : r_look.hit_slot[SW-1:0];

    pabc_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (done && upd.we),
        .i_waddr (upd.slot[SW-1:0]),
        .i_wdata ({upd.total, upd.pending}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // update of the registered item
    pabc_upd u_upd (
        .i_item  (r_item),
        .i_look  (r_look),
        .i_rdata (ram_rdata),
        .o_upd   (upd)
    );

    // record count after this item
    assign cnt_after = r_count + {{(CW-1){1'b0}}, upd.alloc};
    assign cnt_ext   = {5'b00000, cnt_after};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pabc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pabc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pabc_pkg::S_EXEC;
                end
            end
            pabc_pkg::S_EXEC: begin
                if (done) begin
                    n_state = pabc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pabc_pkg::S_IDLE;
            end
        endcase
    end

    // item and lookup capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
            r_look <= cam_look;
        end
    end

    // record count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (done) begin
                r_count     <= cnt_after;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out.status         <= upd.status;
            r_out.total_received <= upd.total;
            r_out.pending_bytes  <= upd.pending;
            r_out.record_count   <= cnt_ext[pabc_pkg::RC_W-1:0];
        end
    end

`ifndef SYNTH
    // the record count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("record count above table size");

    // an accepted item is always followed by its update cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == pabc_pkg::S_EXEC))
        else $error("accepted item did not enter update");

    // a table full result only when every slot is taken
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == pabc_pkg::ST_FULL)) |-> (r_count == CW'(ENTRIES)))
        else $error("table full reported with free slots");

    // a counter write needs an existing record or a free slot
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && upd.we) |-> (r_look.hit || r_look.free_any))
        else $error("counter write without a slot");
`endif

endmodule

`default_nettype wire

>>> rtl/pabc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pabc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pabc_cam.sv
// key store with valid bits, parallel key compare and free slot search
`default_nettype none

module pabc_cam #(
    parameter int ENTRIES = 16,
    parameter int SW      = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [pabc_pkg::KEY_W-1:0]  i_key,
    input  wire logic                        i_alloc,
    input  wire logic [SW-1:0]               i_slot,
    input  wire logic [pabc_pkg::KEY_W-1:0]  i_new_key,
    output pabc_pkg::t_look                  o_look
);

    logic [ENTRIES-1:0]          r_valid;
    logic [pabc_pkg::KEY_W-1:0]  r_key [ENTRIES];

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_alloc) begin
            r_valid[i_slot] <= 1'b1;
        end
    end

    // key registers, written when a record is created
    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_key[i_slot] <= i_new_key;
        end
    end

    // compare against every valid key, lowest index wins for both searches
    always_comb begin
        o_look = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_key)) begin
                o_look.hit      = 1'b1;
                o_look.hit_slot = pabc_pkg::t_slot'(i);
            end
            if (!r_valid[i]) begin
                o_look.free_any  = 1'b1;
                o_look.free_slot = pabc_pkg::t_slot'(i);
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pabc_upd.sv
// operation decode and saturating counter update for one item
`default_nettype none

module pabc_upd (
    input  wire pabc_pkg::t_in_item                  i_item,
    input  wire pabc_pkg::t_look                     i_look,
    input  wire logic [2*pabc_pkg::CNT_W-1:0]        i_rdata,
    output pabc_pkg::t_upd                           o_upd
);

    // returns {clamped, value} of counter plus signed delta, held in range
    function automatic logic [pabc_pkg::CNT_W:0] sat_add(
        input logic [pabc_pkg::CNT_W-1:0]        ctr,
        input logic signed [pabc_pkg::CNT_W-1:0] delta
    );
        logic [pabc_pkg::CNT_W+1:0] s;
        s = {2'b00, ctr} + {{2{delta[pabc_pkg::CNT_W-1]}}, delta};
        if (s[pabc_pkg::CNT_W+1]) begin
            sat_add = {1'b1, {pabc_pkg::CNT_W{1'b0}}};
        end else if (s[pabc_pkg::CNT_W]) begin
            sat_add = {1'b1, {pabc_pkg::CNT_W{1'b1}}};
        end else begin
            sat_add = {1'b0, s[pabc_pkg::CNT_W-1:0]};
        end
    endfunction

    logic [pabc_pkg::CNT_W-1:0] base_tot;
    logic [pabc_pkg::CNT_W-1:0] base_pend;
    logic [pabc_pkg::CNT_W:0]   sat_tot;
    logic [pabc_pkg::CNT_W:0]   sat_pend;
    logic                       is_recv;
    logic                       clamp;

    // counters of the record as read, zero for a record about to be created
    assign base_tot  = i_look.hit ? i_rdata[2*pabc_pkg::CNT_W-1:pabc_pkg::CNT_W] : '0;
    assign base_pend = i_look.hit ? i_rdata[pabc_pkg::CNT_W-1:0] : '0;
    assign sat_tot   = sat_add(base_tot, i_item.byte_delta);
    assign sat_pend  = sat_add(base_pend, i_item.byte_delta);
    assign is_recv   = (i_item.operation == pabc_pkg::OP_RECEIVE);
    assign clamp     = (is_recv && sat_tot[pabc_pkg::CNT_W]) || sat_pend[pabc_pkg::CNT_W];

    // per operation outcome
    always_comb begin
        o_upd         = '0;
        o_upd.slot    = i_look.hit ? i_look.hit_slot : i_look.free_slot;
        o_upd.status  = pabc_pkg::ST_OK;
        case (i_item.operation)
            pabc_pkg::OP_INSERT: begin
                if (i_look.hit) begin
                    o_upd.status  = pabc_pkg::ST_EXISTS;
                    o_upd.total   = base_tot;
                    o_upd.pending = base_pend;
                end else if (i_look.free_any) begin
                    o_upd.we    = 1'b1;
                    o_upd.alloc = 1'b1;
                end else begin
                    o_upd.status = pabc_pkg::ST_FULL;
                end
            end
            pabc_pkg::OP_QUERY: begin
                if (i_look.hit) begin
                    o_upd.total   = base_tot;
                    o_upd.pending = base_pend;
                end else begin
                    o_upd.status = pabc_pkg::ST_NOTFOUND;
                end
            end
            pabc_pkg::OP_RECEIVE, pabc_pkg::OP_ADJUST: begin
                if (!i_look.hit && !i_look.free_any) begin
                    o_upd.status = pabc_pkg::ST_FULL;
                end else begin
                    o_upd.we      = 1'b1;
                    o_upd.alloc   = !i_look.hit;
                    o_upd.total   = is_recv ? sat_tot[pabc_pkg::CNT_W-1:0] : base_tot;
                    o_upd.pending = sat_pend[pabc_pkg::CNT_W-1:0];
                    o_upd.status  = clamp ? pabc_pkg::ST_CLAMPED : pabc_pkg::ST_OK;
                end
            end
            default: begin
                o_upd.status = pabc_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the per-address byte counter table
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_SLOTS = 16;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_HEAVY
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    pabc_pkg::t_in_item   i_in = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    pabc_pkg::t_out_item  o_out;

    // shadow copy of the counter table
    logic        table_valid [TABLE_SLOTS];
    logic [31:0] table_key [TABLE_SLOTS];
    logic [31:0] table_total [TABLE_SLOTS];
    logic [31:0] table_pending [TABLE_SLOTS];
    int          table_used = 0;

    pabc_pkg::t_out_item predicted_replies [$];
    logic [31:0] key_pool [$];
    int          mismatch_count = 0;
    int          burst_left = 0;

    // receiver stall pattern state
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_tick = 0;
    int          rx_period = 4;
    int          rx_hold = 1;

    per_address_byte_counter_table #(
        .ENTRIES(TABLE_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // hard stop if the block hangs
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // add a signed delta to a counter, clamping into 0 .. 2**32-1
    function automatic logic add_clamped(input logic [31:0] ctr, input logic [31:0] delta,
                                         output logic [31:0] res);
        logic signed [33:0] sum;
        sum = $signed({2'b00, ctr}) + $signed({{2{delta[31]}}, delta});
        if (sum < 0) begin
            res = '0;
            return 1'b1;
        end
        if (sum > 34'sh0FFFFFFFF) begin
            res = '1;
            return 1'b1;
        end
        res = sum[31:0];
        return 1'b0;
    endfunction

    // take the lowest free slot for a new key, -1 when the table is full
    function automatic int claim_slot(input logic [31:0] key);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!table_valid[i]) begin
                table_valid[i] = 1'b1;
                table_key[i] = key;
                table_total[i] = '0;
                table_pending[i] = '0;
                table_used++;
                return i;
            end
        end
        return -1;
    endfunction

    // expected reply for one item, updating the shadow table
    function automatic pabc_pkg::t_out_item apply_counter_op(input pabc_pkg::t_in_item item);
        pabc_pkg::t_out_item r;
        int          slot;
        logic        clamped;
        logic [31:0] sum;
        r = '0;
        r.status = pabc_pkg::ST_OK;
        slot = -1;
        clamped = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot < 0 && table_valid[i] && table_key[i] == item.sink_address) slot = i;
        end
        case (item.operation)
            pabc_pkg::OP_INSERT: begin
                if (slot >= 0) begin
                    r.status = pabc_pkg::ST_EXISTS;
                end else begin
                    slot = claim_slot(item.sink_address);
                    if (slot < 0) r.status = pabc_pkg::ST_FULL;
                end
            end
            pabc_pkg::OP_QUERY: begin
                if (slot < 0) r.status = pabc_pkg::ST_NOTFOUND;
            end
            default: begin
                if (slot < 0) slot = claim_slot(item.sink_address);
                if (slot < 0) begin
                    r.status = pabc_pkg::ST_FULL;
                end else begin
                    if (item.operation == pabc_pkg::OP_RECEIVE) begin
                        clamped = add_clamped(table_total[slot], item.byte_delta, sum);
                        table_total[slot] = sum;
                    end
                    if (add_clamped(table_pending[slot], item.byte_delta, sum)) clamped = 1'b1;
                    table_pending[slot] = sum;
                    if (clamped) r.status = pabc_pkg::ST_CLAMPED;
                end
            end
        endcase
        if (slot >= 0) begin
            r.total_received = table_total[slot];
            r.pending_bytes = table_pending[slot];
        end
        r.record_count = table_used[pabc_pkg::RC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // send one item, with bursts and random gaps on the sender side
    task automatic send_op(input pabc_pkg::t_op op, input logic [31:0] key,
                           input logic [31:0] delta);
        pabc_pkg::t_in_item item;
        int       gap;
        item.operation = op;
        item.sink_address = key;
        item.byte_delta = delta;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= item;
        do @(posedge i_clk); while (o_in_stall);
        predicted_replies.push_back(apply_counter_op(item));
        burst_left--;
    endtask

    // stop sending and wait for every reply
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (predicted_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic pool_has(input logic [31:0] key);
        foreach (key_pool[i]) if (key_pool[i] == key) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] key;
        do key = $urandom; while (pool_has(key));
        return key;
    endfunction

    // mix of small, full-range, boundary and large deltas
    function automatic logic [31:0] random_delta();
        logic [31:0] d;
        case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 2000) - 1000;
            1: d = $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: d = 32'h7FFF_FFFF;
                    1: d = 32'h8000_0000;
                    2: d = 32'h0000_0000;
                    3: d = 32'hFFFF_FFFF;
                    default: d = 32'h0000_0001;
                endcase
            end
            default: d = $urandom | 32'h7000_0000;
        endcase
        return d;
    endfunction

    // random items on pool keys; miss_pct of items (of queries only, if miss_query_only is set) use a random key
    task automatic send_random(input int count, input int miss_pct, input logic miss_query_only);
        pabc_pkg::t_op op;
        logic [31:0] key;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) op = pabc_pkg::OP_INSERT;
            else if (pick < 50) op = pabc_pkg::OP_RECEIVE;
            else if (pick < 85) op = pabc_pkg::OP_ADJUST;
            else op = pabc_pkg::OP_QUERY;
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 99) < miss_pct &&
                (!miss_query_only || op == pabc_pkg::OP_QUERY))
                key = $urandom;
            send_op(op, key, random_delta());
        end
    endtask

    // inserts, duplicates and queries on an empty table
    task automatic test_insert_and_query();
        send_op(pabc_pkg::OP_QUERY, 32'h0000_0000, 32'h0);
        send_op(pabc_pkg::OP_INSERT, 32'h0000_0000, 32'h0);
        send_op(pabc_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(pabc_pkg::OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_op(pabc_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h8000_0000);
        send_op(pabc_pkg::OP_QUERY, 32'h1234_5678, 32'h0);
        wait_drained();
    endtask

    // overflow, underflow, and a duplicate insert after a clamp
    task automatic test_counter_clamps();
        send_op(pabc_pkg::OP_RECEIVE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_op(pabc_pkg::OP_RECEIVE, 32'h0000_0000, 32'h7FFF_FFFF);
        send_op(pabc_pkg::OP_RECEIVE, 32'h0000_0000, 32'h0000_0002);
        send_op(pabc_pkg::OP_RECEIVE, 32'h0000_0000, 32'h8000_0000);
        send_op(pabc_pkg::OP_ADJUST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(pabc_pkg::OP_ADJUST, 32'hA5A5_A5A5, 32'h8000_0000);
        send_op(pabc_pkg::OP_RECEIVE, 32'h5A5A_5A5A, 32'hFFFF_FFFB);
        send_op(pabc_pkg::OP_ADJUST, 32'h0000_0000, 32'h7FFF_FFFF);
        send_op(pabc_pkg::OP_INSERT, 32'h5A5A_5A5A, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    // random traffic while the table still has room
    task automatic test_random_partial();
        key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A};
        repeat (8) key_pool.push_back(fresh_key());
        send_random(800, 20, 1'b1);
        wait_drained();
    endtask

    // fill the table, then refuse new keys
    task automatic test_table_full();
        logic [31:0] key;
        while (table_used < TABLE_SLOTS) begin
            key = fresh_key();
            key_pool.push_back(key);
            send_op(pabc_pkg::OP_INSERT, key, $urandom);
        end
        key = fresh_key();
        send_op(pabc_pkg::OP_INSERT, key, 32'h0);
        send_op(pabc_pkg::OP_RECEIVE, key, 32'h0000_0100);
        send_op(pabc_pkg::OP_ADJUST, key, 32'hFFFF_FF00);
        send_op(pabc_pkg::OP_QUERY, key, 32'h0);
        send_op(pabc_pkg::OP_INSERT, key_pool[0], 32'h0);
        wait_drained();
    endtask

    // random traffic on a full table with some misses
    task automatic test_random_full();
        send_random(820, 15, 1'b0);
        wait_drained();
    endtask

    // test sequence
    initial begin
        foreach (table_valid[i]) table_valid[i] = 1'b0;
        @(posedge i_rst_n);
        test_insert_and_query();
        test_counter_clamps();
        test_random_partial();
        test_table_full();
        test_random_full();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver stall pattern, changing mode every so often
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
            rx_period = $urandom_range(2, 7);
            rx_hold = $urandom_range(1, rx_period - 1);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     i_out_stall <= 1'b0;
            RX_COIN:     i_out_stall <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_out_stall <= (rx_tick % rx_period) < rx_hold;
            default:     i_out_stall <= $urandom_range(0, 9) < 8;
        endcase
    end

    // compare each reply with the oldest prediction
    always @(posedge i_clk) begin : check_reply
        pabc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected reply", 32'(o_out.status), 32'h0);
            end else begin
                want = predicted_replies.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", 32'(o_out.status), 32'(want.status));
                if (o_out.total_received !== want.total_received)
                    report_mismatch("total_received", o_out.total_received,
                                    want.total_received);
                if (o_out.pending_bytes !== want.pending_bytes)
                    report_mismatch("pending_bytes", o_out.pending_bytes, want.pending_bytes);
                if (o_out.record_count !== want.record_count)
                    report_mismatch("record_count", 32'(o_out.record_count),
                                    32'(want.record_count));
            end
        end
    end

endmodule
